// ===== design/circular_fifo_with_search_core_defines.svh =====
// Assertion macros shared by the circular FIFO with search design files.
`ifndef CIRCULAR_FIFO_WITH_SEARCH_CORE_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_CORE_DEFINES_SVH

// Check a property on the rising clock edge, skipped while reset is low.
`define CFWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on the rising clock edge, including cycles in reset.
`define CFWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/cfws_pkg.sv =====
// Shared types, codes and constants of the circular FIFO with search.
package cfws_pkg;

    // Fixed field widths
    localparam int CAP_W = 7;
    localparam int CNT_W = 7;
    localparam int POS_W = 6;

    // Parameter defaults
    localparam int DEPTH_DEF      = 64;
    localparam int ITEM_WIDTH_DEF = 32;
    localparam int CAP_RESET_MAX  = 64;

    // Request kinds
    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_PEEK   = 2'd2,
        K_SEARCH = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SRCH = 2'd2,
        S_RESP = 2'd3
    } t_state;

endpackage

// ===== design/cfws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/cfws_step.sv =====
// Shared ring step unit: wrap-around increment of a slot index and item compare.
module cfws_step import cfws_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    input  logic [CAP_W-1:0]         i_cap,
    input  logic [ITEM_WIDTH-1:0]    i_rd_data,
    input  logic [ITEM_WIDTH-1:0]    i_key,
    output logic [$clog2(DEPTH)-1:0] o_nxt,
    output logic                     o_hit
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

    logic [IDX_W:0] w_inc;
    logic           w_wrap;

    // Advance the index and wrap at the capacity
    always_comb begin
        w_inc  = {1'b0, i_idx} + {{IDX_W{1'b0}}, 1'b1};
        w_wrap = CW'(w_inc) >= CW'(i_cap);
        o_nxt  = w_wrap ? '0 : w_inc[IDX_W-1:0];
    end

    // Compare the slot just read against the key
    assign o_hit = (i_rd_data == i_key);

endmodule

// ===== design/circular_fifo_with_search_core.sv =====
// Top level of the circular FIFO with search: sequencer, pointers and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  request | in        | i_valid / o_stall  | i_kind, i_value
//  result  | out       | o_valid / i_stall  | o_status, o_data, o_position, o_is_empty,
//          |           |                    | o_count
//  config  | in        | i_cfg_we           | i_cfg_data (capacity)
//
//  Insert, and any request that fails at once, goes from idle straight to the response
//  state; remove and peek pass through the read state first. Search compares one slot per
//  cycle through the single RAM read port and step unit, at most the count of items, and
//  stops at the first hit. One request is in work at a time; o_stall is high while it is
//  in work. Reset clears pointers, count and state and sets capacity to min(64, DEPTH); no
//  clearing pass. A stalled result holds in the output register while the next request
//  is accepted; a finished request waits in the response state for the register to free.
module circular_fifo_with_search_core import cfws_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_kind,
    input  logic [ITEM_WIDTH-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [ITEM_WIDTH-1:0] o_data,
    output logic [POS_W-1:0]      o_position,
    output logic                  o_is_empty,
    output logic [CNT_W-1:0]      o_count,
    input  logic                  i_cfg_we,
    input  logic [CAP_W-1:0]      i_cfg_data
);

`include "circular_fifo_with_search_core_defines.svh"

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CAP_RST = (DEPTH < CAP_RESET_MAX) ? DEPTH : CAP_RESET_MAX;

    // Sequencer and queue state
    t_state                r_state, n_state;
    logic [CAP_W-1:0]      r_cap, n_cap;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [IDX_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]      r_count, n_count;

    // Request in work
    t_kind                 r_kind, n_kind;
    logic [ITEM_WIDTH-1:0] r_key, n_key;
    logic [IDX_W-1:0]      r_walk, n_walk;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic [CNT_W-1:0]      r_left, n_left;
    t_status               r_st, n_st;
    logic [ITEM_WIDTH-1:0] r_dat, n_dat;
    logic [IDX_W-1:0]      r_pos, n_pos;

    // Output register
    logic                  r_o_valid, n_o_valid;
    t_status               r_o_status, n_o_status;
    logic [ITEM_WIDTH-1:0] r_o_data, n_o_data;
    logic [POS_W-1:0]      r_o_pos, n_o_pos;
    logic                  r_o_empty, n_o_empty;
    logic [CNT_W-1:0]      r_o_count, n_o_count;

    // Control and datapath wires
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [IDX_W-1:0]      w_step_idx;
    logic [IDX_W-1:0]      w_nxt;
    logic                  w_hit;
    logic [ITEM_WIDTH-1:0] w_rd_data;
    logic [CAP_W-1:0]      w_cap_clamp;

    assign w_full     = (r_count >= r_cap);
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_o_valid || !i_stall;

    // Slot store
    cfws_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Shared ring step and compare unit
    cfws_step #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_step (
        .i_idx     (w_step_idx),
        .i_cap     (r_cap),
        .i_rd_data (w_rd_data),
        .i_key     (r_key),
        .o_nxt     (w_nxt),
        .o_hit     (w_hit)
    );

    // Sequencer outputs: handshake, RAM port and step unit operand
    always_comb begin
        o_stall    = (r_state != S_IDLE);
        w_accept   = i_valid && (r_state == S_IDLE);
        w_wr_en    = w_accept && (t_kind'(i_kind) == K_INSERT) && !w_full;
        w_rd_en    = w_accept || (r_state == S_SRCH);
        w_rd_addr  = r_head;
        w_step_idx = r_head;
        unique case (r_state)
            S_IDLE: begin
                w_step_idx = (t_kind'(i_kind) == K_INSERT) ? r_tail : r_head;
            end
            S_READ: begin
                w_step_idx = r_head;
            end
            S_SRCH: begin
                w_rd_addr  = r_walk;
                w_step_idx = r_walk;
            end
            S_RESP: begin
                w_step_idx = r_head;
            end
            default: begin
                w_step_idx = r_head;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_kind'(i_kind)) inside
                        K_INSERT:         n_state = S_RESP;
                        K_REMOVE, K_PEEK: n_state = w_empty ? S_RESP : S_READ;
                        K_SEARCH:         n_state = w_empty ? S_RESP : S_SRCH;
                        default:          n_state = S_RESP;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_SRCH: begin
                if (w_hit || (r_left == CNT_W'(1))) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Clamp a written capacity into 1..DEPTH
    always_comb begin
        w_cap_clamp = i_cfg_data;
        if (i_cfg_data == '0) begin
            w_cap_clamp = CAP_W'(1);
        end else if (int'(i_cfg_data) > DEPTH) begin
            w_cap_clamp = CAP_W'(DEPTH);
        end
    end

    // Queue pointers and request datapath
    always_comb begin
        n_cap   = r_cap;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_kind  = r_kind;
        n_key   = r_key;
        n_walk  = r_walk;
        n_slot  = r_slot;
        n_left  = r_left;
        n_st    = r_st;
        n_dat   = r_dat;
        n_pos   = r_pos;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind = t_kind'(i_kind);
                    n_key  = i_value;
                    n_dat  = '0;
                    n_pos  = '0;
                    n_st   = ST_OK;
                    case (t_kind'(i_kind)) inside
                        K_INSERT: begin
                            if (w_full) begin
                                n_st = ST_FULL;
                            end else begin
                                n_tail  = w_nxt;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        K_REMOVE, K_PEEK: begin
                            if (w_empty) begin
                                n_st = ST_EMPTY;
                            end
                        end
                        default: begin
                            if (w_empty) begin
                                n_st = ST_NOTFOUND;
                            end else begin
                                n_slot = r_head;
                                n_walk = w_nxt;
                                n_left = r_count;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_dat = w_rd_data;
                if (r_kind == K_REMOVE) begin
                    n_head  = w_nxt;
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_SRCH: begin
                if (w_hit) begin
                    n_st  = ST_OK;
                    n_pos = r_slot;
                end else if (r_left == CNT_W'(1)) begin
                    n_st = ST_NOTFOUND;
                end else begin
                    n_slot = r_walk;
                    n_walk = w_nxt;
                    n_left = r_left - CNT_W'(1);
                end
            end
            default: begin
                n_st = r_st;
            end
        endcase
        // Capacity write empties the queue
        if (i_cfg_we) begin
            n_cap   = w_cap_clamp;
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_comb begin
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_data   = r_o_data;
        n_o_pos    = r_o_pos;
        n_o_empty  = r_o_empty;
        n_o_count  = r_o_count;
        if ((r_state == S_RESP) && w_out_free) begin
            n_o_valid  = 1'b1;
            n_o_status = r_st;
            n_o_data   = r_dat;
            n_o_pos    = POS_W'(r_pos);
            n_o_empty  = (r_count == '0);
            n_o_count  = r_count;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CAP_W'(CAP_RST);
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_walk     <= n_walk;
        r_slot     <= n_slot;
        r_left     <= n_left;
        r_st       <= n_st;
        r_dat      <= n_dat;
        r_pos      <= n_pos;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
        r_o_pos    <= n_o_pos;
        r_o_empty  <= n_o_empty;
        r_o_count  <= n_o_count;
    end

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_data     = r_o_data;
    assign o_position = r_o_pos;
    assign o_is_empty = r_o_empty;
    assign o_count    = r_o_count;

    // Queue never holds more items than the capacity
    `CFWS_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= r_cap, "count above capacity")

    // A result appears only out of the response state
    `CFWS_ASSERT(a_valid_src, i_clk, i_rst_n, $rose(o_valid) |-> ($past(r_state) == S_RESP), "result raised outside response state")

    // An accepted insert with room grows the count by one
    `CFWS_ASSERT(a_insert_grow, i_clk, i_rst_n, (w_accept && !i_cfg_we && (t_kind'(i_kind) == K_INSERT) && !w_full) |=> (r_count == $past(r_count) + CNT_W'(1)), "insert did not grow count")

    // The search walk never runs out of items while active
    `CFWS_ASSERT(a_walk_left, i_clk, i_rst_n, (r_state == S_SRCH) |-> (r_left != '0), "search walk past last item")

endmodule

// ===== tb/circular_fifo_with_search_core_test.sv =====
// Self-checking testbench for the circular FIFO with search: random requests against a shadow queue.
`timescale 1ns / 1ps

module circular_fifo_with_search_core_test import cfws_pkg::*;;

    localparam int RING_SLOTS     = DEPTH_DEF;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 80;
    localparam longint LIMIT_NS   = 64'd12_000_000;
    localparam int NUM_PHASES     = 9;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
    } t_fifo_req;

    typedef struct packed {
        t_status          status;
        logic [31:0]      data;
        logic [POS_W-1:0] position;
        logic             is_empty;
        logic [CNT_W-1:0] count;
    } t_fifo_result;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_stall;
    logic [1:0]       i_kind     = K_INSERT;
    logic [31:0]      i_value    = '0;
    logic             o_valid;
    logic             i_stall    = 1'b0;
    logic [1:0]       o_status;
    logic [31:0]      o_data;
    logic [POS_W-1:0] o_position;
    logic             o_is_empty;
    logic [CNT_W-1:0] o_count;
    logic             i_cfg_we   = 1'b0;
    logic [CAP_W-1:0] i_cfg_data = '0;

    // Shadow queue state
    logic [31:0] ring_slots [0:RING_SLOTS-1];
    int          ring_head  = 0;
    int          ring_tail  = 0;
    int          ring_count = 0;
    int          ring_cap   = CAP_RESET_MAX;

    t_fifo_req    pending_reqs[$];
    t_fifo_result expected_results[$];
    logic [31:0]  inserted_values[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit tx_pause     = 1'b0;
    int rx_hold_reqs = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int failures     = 0;

    int phase_cap [0:NUM_PHASES-1] = '{127, 2, 64, 7, 65, 1, 16, 33, 3};
    int phase_len [0:NUM_PHASES-1] = '{160, 130, 160, 130, 130, 110, 160, 160, 140};

    circular_fifo_with_search_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_position (o_position),
        .o_is_empty (o_is_empty),
        .o_count    (o_count),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance a ring index, wrapping at the programmed capacity
    function automatic int ring_step(input int idx);
        return (idx + 1 >= ring_cap) ? 0 : idx + 1;
    endfunction

    // Apply one request to the shadow queue and return the result it should produce
    function automatic t_fifo_result predict_fifo_result(input t_kind kind,
                                                         input logic [31:0] value);
        t_fifo_result res;
        int           slot;
        int           i;
        bit           found;
        res.status   = ST_OK;
        res.data     = '0;
        res.position = '0;
        case (kind) inside
            K_INSERT: begin
                if (ring_count >= ring_cap) begin
                    res.status = ST_FULL;
                end else begin
                    ring_slots[ring_tail] = value;
                    ring_tail = ring_step(ring_tail);
                    ring_count++;
                end
            end
            K_REMOVE, K_PEEK: begin
                if (ring_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = ring_slots[ring_head];
                    if (kind == K_REMOVE) begin
                        ring_head = ring_step(ring_head);
                        ring_count--;
                    end
                end
            end
            default: begin
                // first match from the head wins
                res.status = ST_NOTFOUND;
                slot = ring_head;
                found = 1'b0;
                for (i = 0; i < ring_count; i++) begin
                    if (!found && ring_slots[slot] == value) begin
                        found = 1'b1;
                        res.status = ST_OK;
                        res.position = slot[POS_W-1:0];
                    end
                    slot = ring_step(slot);
                end
            end
        endcase
        res.is_empty = (ring_count == 0);
        res.count    = ring_count[CNT_W-1:0];
        return res;
    endfunction

    // Request driver: predict on accept, then offer the next pending item
    always @(posedge i_clk) begin : request_driver
        t_fifo_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_fifo_result(t_kind'(i_kind), i_value));
            end
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() != 0 && !tx_pause &&
                    $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_kind  <= nxt.kind;
                    i_value <= nxt.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen <= rx_hold_reqs;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Result monitor: compare against the oldest expectation, then pick next stall
    always @(posedge i_clk) begin : result_monitor
        t_fifo_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("unexpected result: status %0d data %h pos %0d empty %0b count %0d",
                                 o_status, o_data, o_position, o_is_empty, o_count);
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status || o_data !== want.data ||
                        o_position !== want.position || o_is_empty !== want.is_empty ||
                        o_count !== want.count) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("mismatch exp: status %0d data %h pos %0d empty %0b count %0d",
                                     want.status, want.data, want.position, want.is_empty,
                                     want.count);
                            $display("         got: status %0d data %h pos %0d empty %0b count %0d",
                                     o_status, o_data, o_position, o_is_empty, o_count);
                        end
                    end
                end
            end
            i_stall <= (rx_hold_left > 0) || ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    task automatic push_req(input t_kind kind, input logic [31:0] value);
        t_fifo_req r;
        r.kind  = kind;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    // Mix of small values (duplicates), full-width noise, extremes and reuse
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return int'($urandom_range(0, 7)) - 4;
        if (r < 70 || inserted_values.size() == 0)
            return $urandom;
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return inserted_values[$urandom_range(0, inserted_values.size() - 1)];
    endfunction

    task automatic push_insert();
        logic [31:0] v;
        v = pick_value();
        inserted_values.push_back(v);
        if (inserted_values.size() > 48)
            void'(inserted_values.pop_front());
        push_req(K_INSERT, v);
    endtask

    task automatic push_search();
        if (inserted_values.size() != 0 && $urandom_range(0, 99) < 55)
            push_req(K_SEARCH, inserted_values[$urandom_range(0, inserted_values.size() - 1)]);
        else
            push_req(K_SEARCH, pick_value());
    endtask

    // Fill/search/drain bursts with random content, plus unstructured requests
    task automatic gen_items(input int n);
        int done;
        int burst;
        int j;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 99) < 60) begin
                burst = $urandom_range(1, ring_cap + 2);
                if (burst > n - done)
                    burst = n - done;
                for (j = 0; j < burst; j++)
                    push_insert();
                done += burst;
                burst = $urandom_range(1, 4);
                for (j = 0; j < burst; j++)
                    push_search();
                done += burst;
                if ($urandom_range(0, 1) == 1) begin
                    push_req(K_PEEK, $urandom);
                    done++;
                end
                burst = $urandom_range(0, ring_cap + 2);
                if (done + burst > n)
                    burst = (n > done) ? n - done : 0;
                for (j = 0; j < burst; j++)
                    push_req(K_REMOVE, $urandom);
                done += burst;
            end else begin
                case (t_kind'($urandom_range(0, 3)))
                    K_INSERT: push_insert();
                    K_REMOVE: push_req(K_REMOVE, $urandom);
                    K_PEEK:   push_req(K_PEEK, $urandom);
                    default:  push_search();
                endcase
                done++;
            end
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
            default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
        endcase
    endtask

    // Hold until every pending item is sent and every result has come back
    task automatic wait_drain();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Write capacity while idle; the write also empties the queue
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (v == 0)
            ring_cap = 1;
        else if (v > RING_SLOTS)
            ring_cap = RING_SLOTS;
        else
            ring_cap = int'(v);
        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
    endtask

    // Stimulus sequence
    initial begin
        int p;
        for (p = 0; p < RING_SLOTS; p++)
            ring_slots[p] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty queue, extremes, duplicates, search order
        push_req(K_REMOVE, 32'h0000_0000);
        push_req(K_PEEK,   32'hFFFF_FFFF);
        push_req(K_SEARCH, 32'h0000_0000);
        push_req(K_INSERT, 32'h8000_0000);
        push_req(K_INSERT, 32'h7FFF_FFFF);
        push_req(K_INSERT, 32'hFFFF_FFFF);
        push_req(K_INSERT, 32'h0000_0000);
        push_req(K_INSERT, 32'h7FFF_FFFF);
        push_req(K_SEARCH, 32'h7FFF_FFFF);
        push_req(K_SEARCH, 32'h0000_0000);
        push_req(K_SEARCH, 32'h1234_5678);
        push_req(K_PEEK,   32'h0000_0000);
        push_req(K_REMOVE, 32'h0000_0000);
        push_req(K_REMOVE, 32'h0000_0000);
        push_req(K_SEARCH, 32'h7FFF_FFFF);
        wait_drain();

        // Capacity of zero is taken as one; write also clears the held items
        write_capacity(7'd0);
        @(negedge i_clk);
        push_req(K_PEEK,   32'h0000_0000);
        push_req(K_INSERT, 32'h5A5A_5A5A);
        push_req(K_INSERT, 32'h0000_0001);
        push_req(K_SEARCH, 32'h5A5A_5A5A);
        push_req(K_REMOVE, 32'h0000_0000);
        push_req(K_REMOVE, 32'h0000_0000);
        push_req(K_INSERT, 32'hA5A5_A5A5);
        push_req(K_PEEK,   32'h0000_0000);
        push_req(K_INSERT, 32'hFFFF_FFFF);
        push_req(K_SEARCH, 32'h0000_0000);
        wait_drain();

        // Random phases over several capacities and idling patterns
        for (p = 0; p < NUM_PHASES; p++) begin
            write_capacity(CAP_W'(phase_cap[p]));
            @(negedge i_clk);
            set_idling(p % 4);
            if (p == 2)
                rx_hold_reqs++;
            gen_items(phase_len[p] / 2);
            while (pending_reqs.size() != 0)
                @(negedge i_clk);
            if (p == 4) begin
                // sender pauses until every outstanding result is back
                tx_pause = 1'b1;
                while (i_valid || expected_results.size() != 0)
                    @(negedge i_clk);
                tx_pause = 1'b0;
            end
            set_idling((p + 1) % 4);
            gen_items(phase_len[p] - phase_len[p] / 2);
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit
    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
